### rtl/core/clmph_pkg.sv
`default_nettype none

package clmph_pkg;

    localparam int CHANNELS  = 64;
    localparam int CH_W      = 6;
    localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LEVEL_W   = 32;
    localparam int PEAK_W    = 3;
    localparam int CNT_W     = 8;
    localparam int LED_W     = 8;
    localparam int NUM_THR   = 6;
    localparam int CFG_IDX_W = 3;

    // floor(x/20) = floor(floor(x/4) * 0xcccccccd / 2^34)
    localparam int                 QIN_W    = LEVEL_W - 2;
    localparam int                 RECIP_W  = 32;
    localparam int                 PROD_W   = QIN_W + RECIP_W;
    localparam int                 RECIP_SH = 34;
    localparam int                 QUOT_W   = PROD_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP_5  = 32'hCCCC_CCCD;

    // threshold slots, clip first down to -60 dBFS
    localparam int THR_CLIP = 0;
    localparam int THR_M6   = 1;
    localparam int THR_M12  = 2;
    localparam int THR_M18  = 3;
    localparam int THR_M30  = 4;
    localparam int THR_M60  = 5;

    typedef logic [NUM_THR-1:0][LEVEL_W-1:0] t_thresholds;

    localparam t_thresholds THR_RESET = {
        32'd2147484,    // -60
        32'd67908744,   // -30
        32'd270352173,  // -18
        32'd539423503,  // -12
        32'd1076291388, // -6
        32'd2147483648  // clip
    };

    localparam logic [CNT_W-1:0] HOLD_RESET = 8'd100;
    localparam logic [CNT_W-1:0] FALL_RESET = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_CLIP    = 3'd0,
        CFG_LEVEL_MINUS6  = 3'd1,
        CFG_LEVEL_MINUS12 = 3'd2,
        CFG_LEVEL_MINUS18 = 3'd3,
        CFG_LEVEL_MINUS30 = 3'd4,
        CFG_LEVEL_MINUS60 = 3'd5,
        CFG_HOLD_TICKS    = 3'd6,
        CFG_FALL_TICKS    = 3'd7
    } t_cfg_idx;

    localparam int LED_GATE_BIT = 6;
    localparam int LED_COMP_BIT = 7;

    typedef struct packed {
        logic [PEAK_W-1:0]  peak_step;
        logic [CNT_W-1:0]   hold_count;
        logic [CNT_W-1:0]   fall_count;
        logic [LEVEL_W-1:0] decayed_level;
    } t_meter_state;

endpackage

`default_nettype wire

### rtl/core/clmph_state_mem.sv
`default_nettype none

module clmph_state_mem
    import clmph_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output t_meter_state      o_rd_data,
    input  wire logic         i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_meter_state i_wr_data
);

    t_meter_state r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;

    t_meter_state      r_rd_data;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_hit;

    // copy of the most recent write, covers a read taken in the same cycle
    t_meter_state      r_byp_data;
    logic [ADDR_W-1:0] r_byp_addr;
    logic              r_byp_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_byp_data <= i_wr_data;
            r_byp_addr <= i_wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_hit  <= 1'b0;
            r_byp_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
                r_byp_vld          <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        if (r_byp_vld && (r_byp_addr == r_rd_addr)) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_hit) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/clmph_decay.sv
`default_nettype none

module clmph_decay
    import clmph_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [LEVEL_W-1:0] i_level,
    output logic [QUOT_W-1:0]       o_quot
);

    logic [PROD_W-1:0] w_prod;
    logic [QUOT_W-1:0] r_quot;

    // level/4 times the reciprocal of 5
    assign w_prod = PROD_W'(i_level[LEVEL_W-1:2]) * PROD_W'(RECIP_5);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= w_prod[PROD_W-1:RECIP_SH];
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

### rtl/core/channel_led_meter_peak_hold.sv
`default_nettype none

// Per-channel LED bar meter with peak hold and a decaying level.
// Input stream (s_axis): one transaction is one meter tick for one channel.
// Output stream (m_axis): one LED mask per tick, in input order.
// Configuration: write enable, register index and data; a write takes
// effect at the clock edge where i_cfg_we is high. Writes are to come only
// while no tick is in flight; the block itself does not enforce this.
// Per-channel state sits in one 64-entry memory with a registered read:
// read at acceptance, peak update and divide-by-20 product, write-back,
// LED bars, output register.
// Throughput: one tick per cycle for differing channels while the receiver
// takes the masks; a tick for a channel still between read and write-back
// waits until that channel has been written back.
// Reset: thresholds and tick counts return to their defaults, all channel
// state reads as zero at once (per-entry valid bits), no clearing pass.
// A stalled receiver fills the output register and the stages behind it;
// s_axis_tready drops once the first stage cannot move, or while the input channel waits for write-back.
module channel_led_meter_peak_hold
    import clmph_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [39:0]          s_axis_tdata,  // channel, level, gate_active, comp_active
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // out_channel, leds, zero pad
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEVEL_W-1:0]   i_cfg_data
);

    function automatic logic [NUM_THR-1:0] f_bars(input logic [LEVEL_W-1:0] v,
                                                 input t_thresholds thr);
        logic [NUM_THR-1:0] m;
        for (int i = 0; i < NUM_THR; i++) begin
            m[NUM_THR-1-i] = (v >= thr[i]);
        end
        return m;
    endfunction

    function automatic logic [PEAK_W-1:0] f_classify(input logic [NUM_THR-1:0] m);
        logic [PEAK_W-1:0] c;
        c = '0;
        for (int i = 0; i < NUM_THR; i++) begin
            if (m[i]) begin
                c = PEAK_W'(i + 1);
            end
        end
        return c;
    endfunction

    // configuration
    t_thresholds      r_thr;
    logic [CNT_W-1:0] r_hold_ticks;
    logic [CNT_W-1:0] r_fall_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THR_RESET;
            r_hold_ticks <= HOLD_RESET;
            r_fall_ticks <= FALL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEVEL_CLIP:    r_thr[THR_CLIP] <= i_cfg_data;
                CFG_LEVEL_MINUS6:  r_thr[THR_M6]   <= i_cfg_data;
                CFG_LEVEL_MINUS12: r_thr[THR_M12]  <= i_cfg_data;
                CFG_LEVEL_MINUS18: r_thr[THR_M18]  <= i_cfg_data;
                CFG_LEVEL_MINUS30: r_thr[THR_M30]  <= i_cfg_data;
                CFG_LEVEL_MINUS60: r_thr[THR_M60]  <= i_cfg_data;
                CFG_HOLD_TICKS:    r_hold_ticks    <= i_cfg_data[CNT_W-1:0];
                CFG_FALL_TICKS:    r_fall_ticks    <= i_cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // input fields
    logic [CH_W-1:0]    w_in_ch;
    logic [LEVEL_W-1:0] w_in_lvl;
    logic               w_in_gate;
    logic               w_in_comp;

    assign w_in_ch   = s_axis_tdata[5:0];
    assign w_in_lvl  = s_axis_tdata[37:6];
    assign w_in_gate = s_axis_tdata[38];
    assign w_in_comp = s_axis_tdata[39];

    // pipeline registers
    logic               r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;
    logic [CH_W-1:0]    r_s1_ch, r_s2_ch, r_s3_ch, r_out_ch;
    logic [LEVEL_W-1:0] r_s1_lvl, r_s2_lvl;
    logic               r_s1_gate, r_s2_gate, r_s3_gate;
    logic               r_s1_comp, r_s2_comp, r_s3_comp;
    logic [PEAK_W-1:0]  r_s2_peak, r_s3_peak;
    logic [CNT_W-1:0]   r_s2_hold, r_s2_fall;
    logic [LEVEL_W-1:0] r_s2_dec, r_s3_dec;
    logic               r_s2_gt;
    logic [LED_W-1:0]   r_out_leds;

    // flow control
    logic w_out_free, w_s3_free, w_s2_free, w_s1_free;
    logic w_s3_adv, w_s2_adv, w_s1_adv, w_hazard, w_in_fire;

    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_s3_adv   = r_s3_vld && w_out_free;
    assign w_s3_free  = !r_s3_vld || w_out_free;
    assign w_s2_adv   = r_s2_vld && w_s3_free;
    assign w_s2_free  = !r_s2_vld || w_s3_free;
    assign w_s1_adv   = r_s1_vld && w_s2_free;
    assign w_s1_free  = !r_s1_vld || w_s2_free;

    // a channel between read and write-back must land before it is read again
    assign w_hazard = (r_s1_vld && (r_s1_ch == w_in_ch))
                   || (r_s2_vld && (r_s2_ch == w_in_ch));

    assign s_axis_tready = w_s1_free && !w_hazard;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // state memory
    t_meter_state w_rd_state;
    t_meter_state w_wr_state;
    logic         w_wr_en;
    logic [LEVEL_W-1:0] w_new_dec;
    logic [QUOT_W-1:0]  w_quot;

    function automatic logic f_in_range(input logic [CH_W-1:0] ch);
        return ({1'b0, ch} < (CH_W + 1)'(CHANNELS));
    endfunction

    clmph_state_mem u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_fire),
        .i_rd_addr (ADDR_W'(w_in_ch)),
        .o_rd_data (w_rd_state),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (ADDR_W'(r_s2_ch)),
        .i_wr_data (w_wr_state)
    );

    clmph_decay u_decay (
        .i_clk   (i_clk),
        .i_en    (w_s1_adv),
        .i_level (w_rd_state.decayed_level),
        .o_quot  (w_quot)
    );

    // stage 1: classify and step the peak
    logic [PEAK_W-1:0] w_cur;
    logic [PEAK_W-1:0] n_peak;
    logic [CNT_W-1:0]  n_hold;
    logic [CNT_W-1:0]  n_fall;

    assign w_cur = f_classify(f_bars(r_s1_lvl, r_thr));

    always_comb begin
        n_peak = w_rd_state.peak_step;
        n_hold = w_rd_state.hold_count;
        n_fall = w_rd_state.fall_count;
        if (w_cur >= w_rd_state.peak_step) begin
            n_peak = w_cur;
            n_hold = r_hold_ticks;
        end else if (w_rd_state.hold_count != '0) begin
            n_hold = w_rd_state.hold_count - 1'b1;
            n_fall = r_fall_ticks;
        end else if (w_rd_state.fall_count != '0) begin
            n_fall = w_rd_state.fall_count - 1'b1;
        end else begin
            n_peak = w_rd_state.peak_step - 1'b1;
            n_fall = r_fall_ticks;
        end
    end

    // stage 2: decayed level and write-back
    assign w_new_dec = r_s2_gt ? r_s2_lvl : (r_s2_dec - LEVEL_W'(w_quot));

    assign w_wr_state.peak_step     = r_s2_peak;
    assign w_wr_state.hold_count    = r_s2_hold;
    assign w_wr_state.fall_count    = r_s2_fall;
    assign w_wr_state.decayed_level = w_new_dec;
    assign w_wr_en = w_s2_adv && f_in_range(r_s2_ch);

    // stage 3: led mask
    logic [LED_W-1:0] w_leds;

    always_comb begin
        w_leds = {2'b00, f_bars(r_s3_dec, r_thr)};
        if (r_s3_peak != '0) begin
            w_leds = w_leds | (LED_W'(1) << (r_s3_peak - 1'b1));
        end
        w_leds[LED_GATE_BIT] = r_s3_gate;
        w_leds[LED_COMP_BIT] = r_s3_comp;
        if (!f_in_range(r_s3_ch)) begin
            w_leds = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_vld <= w_in_fire;
            end
            if (w_s2_free) begin
                r_s2_vld <= w_s1_adv;
            end
            if (w_s3_free) begin
                r_s3_vld <= w_s2_adv;
            end
            if (w_out_free) begin
                r_out_vld <= w_s3_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_ch   <= w_in_ch;
            r_s1_lvl  <= w_in_lvl;
            r_s1_gate <= w_in_gate;
            r_s1_comp <= w_in_comp;
        end
        if (w_s1_adv) begin
            r_s2_ch   <= r_s1_ch;
            r_s2_lvl  <= r_s1_lvl;
            r_s2_gate <= r_s1_gate;
            r_s2_comp <= r_s1_comp;
            r_s2_peak <= n_peak;
            r_s2_hold <= n_hold;
            r_s2_fall <= n_fall;
            r_s2_dec  <= w_rd_state.decayed_level;
            r_s2_gt   <= (r_s1_lvl > w_rd_state.decayed_level);
        end
        if (w_s2_adv) begin
            r_s3_ch   <= r_s2_ch;
            r_s3_gate <= r_s2_gate;
            r_s3_comp <= r_s2_comp;
            r_s3_peak <= r_s2_peak;
            r_s3_dec  <= w_new_dec;
        end
        if (w_s3_adv) begin
            r_out_ch   <= r_s3_ch;
            r_out_leds <= w_leds;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_leds, r_out_ch};

endmodule

`default_nettype wire
